### design/assert_macros.svh
// Assertion helper macros for the RTL of the CBOR tokenizer.
// Each macro expands to one labeled concurrent assertion on clk, gated by rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons must hold at the next clock edge.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/cbor_tok_pkg.sv
// Shared widths, token kinds and error codes for the CBOR item tokenizer.
// No dependencies; used by cbor_item_stream_tokenizer.
package cbor_tok_pkg;

  localparam int MAX_NEST_DEPTH = 8;
  localparam int SP_W           = $clog2(MAX_NEST_DEPTH + 1);
  localparam int CNT_W          = 33;
  localparam int ARG_W          = 64;

  // Output tdata layout, lowest bit first
  localparam int OD_MAJ_LO  = 0;
  localparam int OD_ARG_LO  = 3;
  localparam int OD_PAY_LO  = OD_ARG_LO + ARG_W;
  localparam int OD_DEP_LO  = OD_PAY_LO + 8;
  localparam int OD_ERR_LO  = OD_DEP_LO + 4;
  localparam int OD_USED_W  = OD_ERR_LO + 3;
  localparam int OUT_TDATA_W = ((OD_USED_W + 7) / 8) * 8;

  localparam logic [1:0] TK_HEAD = 2'd0;
  localparam logic [1:0] TK_PAY  = 2'd1;
  localparam logic [1:0] TK_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RSV_INFO = 3'd1;
  localparam logic [2:0] ERR_MAJOR    = 3'd2;
  localparam logic [2:0] ERR_DEEP     = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;
  localparam logic [2:0] ERR_LARGE    = 3'd5;

  localparam logic [2:0] MT_BSTR  = 3'd2;
  localparam logic [2:0] MT_TSTR  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [2:0] MT_TAG   = 3'd6;

  localparam logic [4:0] AI_ONE_BYTE = 5'd24;
  localparam logic [4:0] AI_RSV_LO   = 5'd28;

endpackage

### design/cbor_item_stream_tokenizer.sv
// Top level of the streaming CBOR item tokenizer: byte in, token out.
// Depends on cbor_tok_pkg and assert_macros.svh.
//
// Feed the encoded buffer one byte per item on the in_ stream, with in_tlast on
// its final byte. Each byte passes through an input register and then the
// result register, and a byte can enter every cycle unless a full result
// register waits on out_tready; the only loop is the per-byte update of the
// parser state (head/argument/payload phase, counters and the nesting stack
// top). Item heads come out as one token with the last argument byte, string
// content bytes come out one token each, and argument bytes before the last one
// give no token. out_tlast marks the token that completes a top-level item.
// Errors give a single error token and then silence up to the buffer's last
// byte; after the last byte the parser starts clean. No clearing pass after reset.
`include "assert_macros.svh"

module cbor_item_stream_tokenizer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // data_byte
  input  logic                                in_tlast,   // last_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] major_type, [66:3] argument, [74:67] payload_byte,
  // [78:75] nest_depth, [81:79] error_code, rest zero
  output logic [cbor_tok_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                          out_tuser,  // token_kind
  output logic                                out_tlast   // item_end
);

  localparam int MAXD  = cbor_tok_pkg::MAX_NEST_DEPTH;
  localparam int SP_W  = cbor_tok_pkg::SP_W;
  localparam int CNT_W = cbor_tok_pkg::CNT_W;
  localparam int ARG_W = cbor_tok_pkg::ARG_W;

  typedef enum logic [1:0] {PH_HEAD, PH_ARG, PH_PAY} phase_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // input register
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic [2:0]        maj_r, maj_nxt;
  logic [3:0]        abl_r, abl_nxt;
  logic [ARG_W-1:0]  acc_r, acc_nxt;
  logic [31:0]       pay_r, pay_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  cnt_t              stk_r [MAXD];
  cnt_t              stk_nxt [MAXD];
  logic [2:0]        err_r, err_nxt;

  // result register
  logic              out_v_r;
  logic [1:0]        o_kind_r;
  logic [2:0]        o_maj_r;
  logic [ARG_W-1:0]  o_arg_r;
  logic [7:0]        o_pay_r;
  logic [3:0]        o_dep_r;
  logic              o_end_r;
  logic [2:0]        o_err_r;

  // token being built
  logic              have;
  logic [1:0]        tk_kind;
  logic [2:0]        tk_maj;
  logic [ARG_W-1:0]  tk_arg;
  logic [7:0]        tk_pay;
  logic [SP_W-1:0]   tk_dep;
  logic              tk_end;
  logic [2:0]        tk_err;

  logic              out_free, adv, in_acc;
  logic              hd_go, fin_go;
  logic [ARG_W-1:0]  hd_arg, acc_shift;
  logic [3:0]        abl_dec;
  logic [31:0]       pay_dec;
  logic [4:0]        ai;
  logic [2:0]        b_maj;

  // pop of exhausted containers
  logic [SP_W-1:0]   pop_k, pop_sp;
  logic              pop_end;
  cnt_t              pop_sh [MAXD];

  assign out_free  = !out_v_r || out_tready;
  assign adv       = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign ai        = s1_byte_r[4:0];
  assign b_maj     = s1_byte_r[7:5];
  assign acc_shift = {acc_r[ARG_W-9:0], s1_byte_r};
  assign abl_dec   = (abl_r != 4'd0) ? abl_r - 4'd1 : 4'd0;
  assign pay_dec   = (pay_r != 32'd0) ? pay_r - 32'd1 : 32'd0;

  // Count the run of entries holding one, from the stack top down: each of
  // those drops to zero and pops, then the first other entry is decremented.
  always_comb begin
    logic run;
    run   = 1'b1;
    pop_k = '0;
    for (int i = 0; i < MAXD; i++) begin
      if (run && (SP_W'(i) < sp_r) && (stk_r[i] == cnt_t'(1))) begin
        pop_k = pop_k + SP_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    for (int j = 0; j < MAXD; j++) begin
      pop_sh[j] = stk_r[j];
      for (int m = j; m < MAXD; m++) begin
        if (SP_W'(m - j) == pop_k) begin
          pop_sh[j] = stk_r[m];
        end
      end
    end
    pop_end = (pop_k == sp_r);
    pop_sp  = sp_r - pop_k;
  end

  always_comb begin
    logic [2:0]  hd_maj;
    logic        big, is_cont, is_str;
    phase_nxt = phase_r;
    maj_nxt   = maj_r;
    abl_nxt   = abl_r;
    acc_nxt   = acc_r;
    pay_nxt   = pay_r;
    sp_nxt    = sp_r;
    stk_nxt   = stk_r;
    err_nxt   = err_r;
    have      = 1'b0;
    tk_kind   = cbor_tok_pkg::TK_HEAD;
    tk_maj    = maj_r;
    tk_arg    = '0;
    tk_pay    = '0;
    tk_dep    = sp_r;
    tk_end    = 1'b0;
    tk_err    = cbor_tok_pkg::ERR_NONE;
    hd_go     = 1'b0;
    hd_arg    = ARG_W'(ai);
    fin_go    = 1'b0;

    if (err_r == cbor_tok_pkg::ERR_NONE) begin
      unique case (phase_r)
        PH_HEAD: begin
          maj_nxt = b_maj;
          tk_maj  = b_maj;
          if (b_maj >= cbor_tok_pkg::MT_TAG) begin
            have    = 1'b1;
            tk_kind = cbor_tok_pkg::TK_ERR;
            err_nxt = cbor_tok_pkg::ERR_MAJOR;
          end else if (ai >= cbor_tok_pkg::AI_RSV_LO) begin
            have    = 1'b1;
            tk_kind = cbor_tok_pkg::TK_ERR;
            err_nxt = cbor_tok_pkg::ERR_RSV_INFO;
          end else if (ai < cbor_tok_pkg::AI_ONE_BYTE) begin
            hd_go = 1'b1;
          end else begin
            // info 24..27 -> 1, 2, 4 or 8 argument bytes
            abl_nxt   = 4'd1 << ai[1:0];
            acc_nxt   = '0;
            phase_nxt = PH_ARG;
          end
        end
        PH_ARG: begin
          acc_nxt = acc_shift;
          abl_nxt = abl_dec;
          if (abl_dec == 4'd0) begin
            phase_nxt = PH_HEAD;
            hd_go     = 1'b1;
            hd_arg    = acc_shift;
          end
        end
        PH_PAY: begin
          have    = 1'b1;
          tk_kind = cbor_tok_pkg::TK_PAY;
          tk_pay  = s1_byte_r;
          pay_nxt = pay_dec;
          if (pay_dec == 32'd0) begin
            phase_nxt = PH_HEAD;
            fin_go    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    hd_maj  = maj_nxt;
    big     = (hd_arg[ARG_W-1:32] != '0);
    is_cont = (hd_maj == cbor_tok_pkg::MT_ARRAY) || (hd_maj == cbor_tok_pkg::MT_MAP);
    is_str  = (hd_maj == cbor_tok_pkg::MT_BSTR) || (hd_maj == cbor_tok_pkg::MT_TSTR);

    if (hd_go) begin
      have   = 1'b1;
      tk_maj = hd_maj;
      tk_arg = hd_arg;
      if ((is_cont || is_str) && big) begin
        tk_kind = cbor_tok_pkg::TK_ERR;
        tk_arg  = '0;
        err_nxt = cbor_tok_pkg::ERR_LARGE;
      end else if (is_cont && (hd_arg != '0)) begin
        if (sp_r >= SP_W'(MAXD)) begin
          tk_kind = cbor_tok_pkg::TK_ERR;
          tk_arg  = '0;
          err_nxt = cbor_tok_pkg::ERR_DEEP;
        end else begin
          // a map counts keys and values separately
          stk_nxt[0] = (hd_maj == cbor_tok_pkg::MT_MAP) ? {hd_arg[31:0], 1'b0}
                                                         : {1'b0, hd_arg[31:0]};
          for (int j = 1; j < MAXD; j++) begin
            stk_nxt[j] = stk_r[j-1];
          end
          sp_nxt = sp_r + SP_W'(1);
        end
      end else if (is_str && (hd_arg != '0)) begin
        pay_nxt   = hd_arg[31:0];
        phase_nxt = PH_PAY;
      end else begin
        fin_go = 1'b1;
      end
    end

    if (fin_go) begin
      tk_end  = pop_end;
      sp_nxt  = pop_sp;
      stk_nxt = pop_sh;
      stk_nxt[0] = pop_sh[0] - cnt_t'(1);
    end

    if (tk_kind == cbor_tok_pkg::TK_ERR) begin
      tk_err = err_nxt;
    end

    if (s1_last_r) begin
      if ((err_nxt == cbor_tok_pkg::ERR_NONE) &&
          ((phase_nxt != PH_HEAD) || (sp_nxt != '0))) begin
        have    = 1'b1;
        tk_kind = cbor_tok_pkg::TK_ERR;
        tk_maj  = maj_nxt;
        tk_arg  = '0;
        tk_pay  = '0;
        tk_dep  = sp_nxt;
        tk_end  = 1'b0;
        tk_err  = cbor_tok_pkg::ERR_TRUNC;
      end
      phase_nxt = PH_HEAD;
      maj_nxt   = '0;
      abl_nxt   = '0;
      acc_nxt   = '0;
      pay_nxt   = '0;
      sp_nxt    = '0;
      err_nxt   = cbor_tok_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_HEAD;
      maj_r   <= '0;
      abl_r   <= '0;
      acc_r   <= '0;
      pay_r   <= '0;
      sp_r    <= '0;
      err_r   <= cbor_tok_pkg::ERR_NONE;
    end else begin
      if (in_acc) begin
        s1_v_r    <= 1'b1;
        s1_byte_r <= in_tdata;
        s1_last_r <= in_tlast;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end

      if (adv) begin
        phase_r <= phase_nxt;
        maj_r   <= maj_nxt;
        abl_r   <= abl_nxt;
        acc_r   <= acc_nxt;
        pay_r   <= pay_nxt;
        sp_r    <= sp_nxt;
        stk_r   <= stk_nxt;
        err_r   <= err_nxt;
        out_v_r <= have;
        if (have) begin
          o_kind_r <= tk_kind;
          o_maj_r  <= tk_maj;
          o_arg_r  <= tk_arg;
          o_pay_r  <= tk_pay;
          o_dep_r  <= 4'(tk_dep);
          o_end_r  <= tk_end;
          o_err_r  <= tk_err;
        end
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_end_r;
  assign out_tdata  = {{(cbor_tok_pkg::OUT_TDATA_W - cbor_tok_pkg::OD_USED_W){1'b0}},
                       o_err_r, o_dep_r, o_pay_r, o_arg_r, o_maj_r};

  `CHK_ALWAYS(a_sp_bound, sp_r <= SP_W'(MAXD), "nesting stack pointer past its depth")
  `CHK_ALWAYS(a_arg_pending, (phase_r != PH_ARG) || (abl_r != 4'd0), "argument phase with no byte left")
  `CHK_ALWAYS(a_err_token, !(out_v_r && (o_kind_r == cbor_tok_pkg::TK_ERR)) || ((o_err_r != cbor_tok_pkg::ERR_NONE) && !o_end_r), "error token without a code")
  `CHK_NEXT(a_last_clean, adv && s1_last_r, (phase_r == PH_HEAD) && (sp_r == '0) && (err_r == cbor_tok_pkg::ERR_NONE), "parser not clean after last byte")

endmodule
